// ===== rtl/rbs_pkg.sv =====
// Package for the request batching scheduler: sizes, operation and status
// codes, configuration register indexes and the command record.
// No dependencies; every other file in rtl/ but rbs_ram imports it.
`default_nettype none

package rbs_pkg;

  // Queue and field sizes.
  localparam int QUEUE_DEPTH = 64;
  localparam int TAG_BITS    = 10;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int SIZE_W      = 21;
  localparam int COUNT_W     = 16;
  localparam int BYTES_W     = 32;
  localparam int TIMER_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  // Configuration reset values.
  localparam logic [COUNT_W-1:0] BATCH_COUNT_RESET   = 16'd16;
  localparam logic [BYTES_W-1:0] BATCH_BYTES_RESET   = 32'd65536;
  localparam logic [TIMER_W-1:0] BATCH_TIMEOUT_RESET = 16'd50;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_MERGE    = 2'd1,
    OP_DISPATCH = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_ACCEPTED   = 2'd0,
    ST_DISPATCHED = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_FULL       = 2'd3
  } status_t;

  // Back end sequencer states.
  typedef enum logic {
    BK_EXEC = 1'b0,
    BK_POP  = 1'b1
  } bk_state_t;

  // Classified command passed from the front end to the back end.
  typedef struct packed {
    op_t                 op;
    logic [TAG_BITS-1:0] tag;
    logic                at_head;
    logic [SIZE_W-1:0]   wr_bytes;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/request_batching_scheduler.sv =====
// Request batching scheduler: queues request tags and decides when a batch
// goes out. Top level; depends on rbs_pkg, rbs_front and rbs_back.
//
// Input channel (in_valid / in_stall): one transaction is an operation with
// op, tag, is_write, size_bytes and at_head. Output channel (out_valid /
// out_stall): one result transaction per input, with status, out_tag,
// work_pending and occupancy, in input order.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index
// (0 batch count, 1 byte limit, 2 tick limit); other indexes are ignored.
// Write only while no transaction is in flight.
// Latency: a result passes through the command queue and the result register;
// a dispatch that pops a tag also passes through the BK_POP state, since the tag store has a registered read.
// Throughput: one transaction per cycle while out_stall is low, except a
// popping dispatch, which holds the back end in BK_POP. A two-entry command queue separates the
// input side from the back end.
// Reset clears the queue, the counters, the timer and the mode, and loads
// the default thresholds. When out_stall is high the result is held, the
// back end waits, and in_stall rises once the command queue is full.
`default_nettype none

module request_batching_scheduler
  import rbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            op,
  input  wire logic [TAG_BITS-1:0]   tag,
  input  wire logic                  is_write,
  input  wire logic [SIZE_W-1:0]     size_bytes,
  input  wire logic                  at_head,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 status,
  output logic [TAG_BITS-1:0]        out_tag,
  output logic                       work_pending,
  output logic [CNT_W-1:0]           occupancy
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Accept and classify.
  rbs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .tag        (tag),
    .is_write   (is_write),
    .size_bytes (size_bytes),
    .at_head    (at_head),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  // Execute against queue, counters and timer.
  rbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_tag      (out_tag),
    .work_pending (work_pending),
    .occupancy    (occupancy)
  );

endmodule

`default_nettype wire

// ===== rtl/rbs_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/rbs_front.sv =====
// Front end of the scheduler: accepts input transactions, classifies them
// into commands and holds them in a two-entry queue. Depends on rbs_pkg.
`default_nettype none

module rbs_front
  import rbs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          op,
  input  wire logic [TAG_BITS-1:0] tag,
  input  wire logic                is_write,
  input  wire logic [SIZE_W-1:0]   size_bytes,
  input  wire logic                at_head,
  output logic                     cmd_valid,
  input  wire logic                cmd_ready,
  output cmd_t                     cmd
);

  cmd_t       queue [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  cmd_t       cmd_in;

  // Classify: only inserts and merge reports that are writes carry bytes.
  always_comb begin
    cmd_in.op      = op_t'(op);
    cmd_in.tag     = tag;
    cmd_in.at_head = at_head;
    if (is_write && (op_t'(op) == OP_INSERT || op_t'(op) == OP_MERGE)) begin
      cmd_in.wr_bytes = size_bytes;
    end else begin
      cmd_in.wr_bytes = '0;
    end
  end

  assign in_stall  = (fill == 2'd2);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cmd_in;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rbs_back.sv =====
// Back end of the scheduler: carries out commands against the tag queue,
// the batch counters and the timer, and holds the result register.
// Depends on rbs_pkg and rbs_ram.
`default_nettype none

module rbs_back
  import rbs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cmd_valid,
  output logic                       cmd_ready,
  input  wire cmd_t                  cmd,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 status,
  output logic [TAG_BITS-1:0]        out_tag,
  output logic                       work_pending,
  output logic [CNT_W-1:0]           occupancy
);

  // Configuration registers.
  logic [COUNT_W-1:0] batch_count;
  logic [BYTES_W-1:0] byte_limit;
  logic [TIMER_W-1:0] tick_limit;

  // Scheduler state.
  bk_state_t          state, state_next;
  logic [PTR_W-1:0]   head_ptr, head_ptr_next;
  logic [PTR_W-1:0]   tail_ptr, tail_ptr_next;
  logic [CNT_W-1:0]   held_count, held_count_next;
  logic [COUNT_W-1:0] batched_count, batched_count_next;
  logic [BYTES_W-1:0] batched_bytes, batched_bytes_next;
  logic               dispatching, dispatching_next;
  logic               timer_running, timer_running_next;
  logic [TIMER_W-1:0] timer_left, timer_left_next;

  // Result register.
  logic                out_valid_next;
  status_t             status_reg, status_next;
  logic [TAG_BITS-1:0] out_tag_next;
  logic                work_pending_next;
  logic [CNT_W-1:0]    occupancy_next;

  // Tag store port signals.
  logic                ram_we;
  logic [PTR_W-1:0]    ram_waddr;
  logic [PTR_W-1:0]    ram_raddr;
  logic [TAG_BITS-1:0] ram_rdata;

  logic               out_free;
  logic [BYTES_W:0]   bytes_sum;
  logic [BYTES_W-1:0] bytes_added;
  logic [PTR_W:0]     tail_inc;
  logic [PTR_W:0]     head_inc;

  rbs_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (QUEUE_DEPTH)
  ) u_tag_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.tag),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign status    = status_reg;
  assign out_free  = !out_valid || !out_stall;

  // Saturating byte add and pointer increments.
  assign bytes_sum   = {1'b0, batched_bytes} + (BYTES_W + 1)'(cmd.wr_bytes);
  assign bytes_added = bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
  assign tail_inc    = {1'b0, tail_ptr} + (PTR_W + 1)'(1);
  assign head_inc    = {1'b0, head_ptr} + (PTR_W + 1)'(1);

  // Next state, datapath updates and result.
  always_comb begin
    state_next          = state;
    head_ptr_next       = head_ptr;
    tail_ptr_next       = tail_ptr;
    held_count_next     = held_count;
    batched_count_next  = batched_count;
    batched_bytes_next  = batched_bytes;
    dispatching_next    = dispatching;
    timer_running_next  = timer_running;
    timer_left_next     = timer_left;
    out_valid_next      = out_valid && out_stall;
    status_next         = status_reg;
    out_tag_next        = out_tag;
    work_pending_next   = work_pending;
    occupancy_next      = occupancy;
    cmd_ready           = 1'b0;
    ram_we              = 1'b0;
    ram_waddr           = tail_ptr;
    ram_raddr           = head_ptr;

    case (state)
      BK_EXEC: begin
        if (cmd_valid && out_free) begin
          cmd_ready      = 1'b1;
          status_next    = ST_ACCEPTED;
          out_tag_next   = '0;
          out_valid_next = 1'b1;
          case (cmd.op)
            OP_INSERT: begin
              if (held_count == CNT_W'(QUEUE_DEPTH)) begin
                status_next = ST_FULL;
              end else begin
                ram_we = 1'b1;
                if (cmd.at_head) begin
                  head_ptr_next = (head_ptr == '0) ? PTR_W'(QUEUE_DEPTH - 1)
                                                   : head_ptr - PTR_W'(1);
                  ram_waddr     = head_ptr_next;
                end else begin
                  ram_waddr     = tail_ptr;
                  tail_ptr_next = (tail_inc == (PTR_W + 1)'(QUEUE_DEPTH)) ? '0
                                                   : tail_inc[PTR_W-1:0];
                end
                held_count_next = held_count + CNT_W'(1);
                if (batched_count != '1) begin
                  batched_count_next = batched_count + COUNT_W'(1);
                end
                batched_bytes_next = bytes_added;
                if (!dispatching && !timer_running) begin
                  timer_running_next = 1'b1;
                  timer_left_next    = tick_limit;
                end
              end
            end
            OP_MERGE: begin
              batched_bytes_next = bytes_added;
            end
            OP_DISPATCH: begin
              if (held_count == '0) begin
                status_next        = ST_EMPTY;
                batched_count_next = '0;
                batched_bytes_next = '0;
                dispatching_next   = 1'b0;
              end else begin
                // Tag read from the store lands in the next cycle, in BK_POP.
                status_next     = ST_DISPATCHED;
                ram_raddr       = head_ptr;
                head_ptr_next   = (head_inc == (PTR_W + 1)'(QUEUE_DEPTH)) ? '0
                                                 : head_inc[PTR_W-1:0];
                held_count_next = held_count - CNT_W'(1);
                out_valid_next  = 1'b0;
                state_next      = BK_POP;
              end
            end
            OP_TICK: begin
              if (timer_running) begin
                if (timer_left <= TIMER_W'(1)) begin
                  timer_running_next = 1'b0;
                  timer_left_next    = '0;
                  dispatching_next   = 1'b1;
                end else begin
                  timer_left_next = timer_left - TIMER_W'(1);
                end
              end
            end
            default: begin
              status_next = ST_ACCEPTED;
            end
          endcase

          // Threshold check after every command.
          if (!dispatching_next && (batched_count_next >= batch_count ||
                                    batched_bytes_next >= byte_limit)) begin
            dispatching_next   = 1'b1;
            timer_running_next = 1'b0;
            timer_left_next    = '0;
          end
          work_pending_next = dispatching_next;
          occupancy_next    = held_count_next;
        end
      end
      BK_POP: begin
        out_tag_next   = ram_rdata;
        out_valid_next = 1'b1;
        state_next     = BK_EXEC;
      end
      default: begin
        state_next = BK_EXEC;
      end
    endcase
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= BK_EXEC;
      head_ptr      <= '0;
      tail_ptr      <= '0;
      held_count    <= '0;
      batched_count <= '0;
      batched_bytes <= '0;
      dispatching   <= 1'b0;
      timer_running <= 1'b0;
      timer_left    <= '0;
      out_valid     <= 1'b0;
      batch_count   <= BATCH_COUNT_RESET;
      byte_limit    <= BATCH_BYTES_RESET;
      tick_limit    <= BATCH_TIMEOUT_RESET;
    end else begin
      state         <= state_next;
      head_ptr      <= head_ptr_next;
      tail_ptr      <= tail_ptr_next;
      held_count    <= held_count_next;
      batched_count <= batched_count_next;
      batched_bytes <= batched_bytes_next;
      dispatching   <= dispatching_next;
      timer_running <= timer_running_next;
      timer_left    <= timer_left_next;
      out_valid     <= out_valid_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BATCH_COUNT:   batch_count <= cfg_data[COUNT_W-1:0];
          CFG_BATCH_BYTES:   byte_limit  <= cfg_data[BYTES_W-1:0];
          CFG_BATCH_TIMEOUT: tick_limit  <= cfg_data[TIMER_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    status_reg   <= status_next;
    out_tag      <= out_tag_next;
    work_pending <= work_pending_next;
    occupancy    <= occupancy_next;
  end

endmodule

`default_nettype wire

// ===== bench/tb_request_batching_scheduler.sv =====
// Self-checking bench for the request batching scheduler: a directed table and
// random batching traffic, scored against a model; checked rows carry their own results.
// Depends on rbs_pkg and the request_batching_scheduler top level.
module tb_request_batching_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import rbs_pkg::*;

  localparam int RANDOM_ITEMS      = 1600;
  localparam int QUIET_ITEMS       = 250;
  localparam int HOLD_CYCLES       = 80;
  localparam int STUCK_LIMIT       = 2000;
  localparam int DRAIN_CYCLES      = 4;
  localparam int TAIL_CYCLES       = 10;
  localparam int MAX_REQ_BYTES     = 1048576;
  localparam logic [COUNT_W-1:0]   COUNT_MAX  = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    op_t                 op;
    logic [TAG_BITS-1:0] tag;
    logic                is_write;
    logic [SIZE_W-1:0]   size;
    logic                at_head;
  } request_t;

  typedef struct packed {
    status_t             status;
    logic [TAG_BITS-1:0] tag;
    logic                work_pending;
    logic [CNT_W-1:0]    occupancy;
  } result_t;

  // One row of the directed table: a register write or a request.
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    request_t              rq;
    logic                  typed;
    result_t               res;
  } step_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [1:0] op;
  logic [TAG_BITS-1:0] tag;
  logic is_write;
  logic [SIZE_W-1:0] size_bytes;
  logic at_head;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic out_valid;
  logic out_stall;
  logic [1:0] status;
  logic [TAG_BITS-1:0] out_tag;
  logic work_pending;
  logic [CNT_W-1:0] occupancy;

  // Model of the queue, the batch counters, the timer and the thresholds.
  logic [TAG_BITS-1:0] model_tags [QUEUE_DEPTH];
  logic [PTR_W-1:0]    model_head;
  logic [PTR_W-1:0]    model_tail;
  logic [CNT_W-1:0]    model_held;
  logic [COUNT_W-1:0]  model_count;
  logic [BYTES_W-1:0]  model_bytes;
  logic                model_dispatching;
  logic                model_timer_on;
  logic [TIMER_W-1:0]  model_timer;
  logic [COUNT_W-1:0]  limit_count;
  logic [BYTES_W-1:0]  limit_bytes;
  logic [TIMER_W-1:0]  limit_timeout;

  result_t outstanding_results [$];
  step_t   directed_steps [$];
  logic    drive_fixed;
  result_t drive_answer;
  int      requests_sent = 0;
  int      failures = 0;
  int      stuck_cycles = 0;
  int      gap_odds = 20;
  int      stall_odds = 20;
  bit      quiet = 1'b0;
  bit      long_hold = 1'b0;

  request_batching_scheduler i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [BYTES_W-1:0] add_clamped(logic [BYTES_W-1:0] a,
                                                     logic [SIZE_W-1:0] b);
    logic [BYTES_W:0] sum;
    sum = {1'b0, a} + b;
    return sum[BYTES_W] ? '1 : sum[BYTES_W-1:0];
  endfunction

  // Applies one request to the model and returns the result it must produce.
  function automatic result_t schedule_step(request_t rq);
    result_t r;
    r.status = ST_ACCEPTED;
    r.tag = '0;
    case (rq.op)
      OP_INSERT: begin
        if (model_held >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (rq.at_head) begin
            model_head = (model_head == 0) ? PTR_W'(QUEUE_DEPTH - 1) : model_head - 1'b1;
            model_tags[model_head] = rq.tag;
          end else begin
            model_tags[model_tail] = rq.tag;
            model_tail = (model_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : model_tail + 1'b1;
          end
          model_held = model_held + 1'b1;
          if (model_count != COUNT_MAX) model_count = model_count + 1'b1;
          if (rq.is_write) model_bytes = add_clamped(model_bytes, rq.size);
          // The timer is armed by the first insert of a batch.
          if (!model_dispatching && !model_timer_on) begin
            model_timer_on = 1'b1;
            model_timer = limit_timeout;
          end
        end
      end
      OP_MERGE: begin
        if (rq.is_write) model_bytes = add_clamped(model_bytes, rq.size);
      end
      OP_DISPATCH: begin
        if (model_held == 0) begin
          r.status = ST_EMPTY;
          model_count = '0;
          model_bytes = '0;
          model_dispatching = 1'b0;
        end else begin
          r.status = ST_DISPATCHED;
          r.tag = model_tags[model_head];
          model_head = (model_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : model_head + 1'b1;
          model_held = model_held - 1'b1;
        end
      end
      OP_TICK: begin
        // A timeout of zero expires on the first tick, like a timeout of one.
        if (model_timer_on) begin
          if (model_timer <= 1) begin
            model_timer_on = 1'b0;
            model_timer = '0;
            model_dispatching = 1'b1;
          end else begin
            model_timer = model_timer - 1'b1;
          end
        end
      end
    endcase
    // Either threshold ends batching and cancels the timer.
    if (!model_dispatching && (model_count >= limit_count || model_bytes >= limit_bytes)) begin
      model_dispatching = 1'b1;
      model_timer_on = 1'b0;
      model_timer = '0;
    end
    r.work_pending = model_dispatching;
    r.occupancy = model_held;
    return r;
  endfunction

  function automatic request_t random_request(op_t kind);
    request_t rq;
    rq.op = kind;
    rq.tag = TAG_BITS'($urandom);
    rq.is_write = 1'($urandom);
    rq.at_head = 1'($urandom);
    case ($urandom_range(0, 7))
      0:       rq.size = '0;
      1:       rq.size = SIZE_W'(MAX_REQ_BYTES);
      2, 3:    rq.size = SIZE_W'($urandom_range(0, MAX_REQ_BYTES));
      default: rq.size = SIZE_W'($urandom_range(0, 16384));
    endcase
    return rq;
  endfunction

  function automatic step_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t plain_row(op_t o, logic [TAG_BITS-1:0] t, logic w,
                                      logic [SIZE_W-1:0] sz, logic hd);
    step_t s;
    s = '0;
    s.rq = '{o, t, w, sz, hd};
    return s;
  endfunction

  function automatic step_t checked_row(op_t o, logic [TAG_BITS-1:0] t, logic w,
                                        logic [SIZE_W-1:0] sz, logic hd, status_t st,
                                        logic [TAG_BITS-1:0] ot, logic hw,
                                        logic [CNT_W-1:0] occ);
    step_t s;
    s = plain_row(o, t, w, sz, hd);
    s.typed = 1'b1;
    s.res = '{st, ot, hw, occ};
    return s;
  endfunction

  // Offers one request, after an occasional random gap, and waits until it is taken.
  task automatic send_request(request_t rq, logic typed = 1'b0, result_t fixed = '0);
    if (!quiet && gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    op = rq.op;
    tag = rq.tag;
    is_write = rq.is_write;
    size_bytes = rq.size;
    at_head = rq.at_head;
    drive_fixed = typed;
    drive_answer = fixed;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Result side: random stall bursts, and one long hold-off on request.
  initial begin
    bit held_off;
    held_off = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !held_off) begin
        held_off = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (!quiet && stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 6)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Scoreboard: predict each accepted transaction and check each result in order.
  always @(posedge clk) begin
    result_t  want;
    request_t seen;
    bit       moved;
    moved = 1'b0;
    if (rst) begin
      model_head = '0;
      model_tail = '0;
      model_held = '0;
      model_count = '0;
      model_bytes = '0;
      model_dispatching = 1'b0;
      model_timer_on = 1'b0;
      model_timer = '0;
      limit_count = BATCH_COUNT_RESET;
      limit_bytes = BATCH_BYTES_RESET;
      limit_timeout = BATCH_TIMEOUT_RESET;
      stuck_cycles = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BATCH_COUNT:   limit_count = cfg_data[COUNT_W-1:0];
          CFG_BATCH_BYTES:   limit_bytes = cfg_data[BYTES_W-1:0];
          CFG_BATCH_TIMEOUT: limit_timeout = cfg_data[TIMER_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        seen.op = op_t'(op);
        seen.tag = tag;
        seen.is_write = is_write;
        seen.size = size_bytes;
        seen.at_head = at_head;
        want = schedule_step(seen);
        outstanding_results.push_back(drive_fixed ? drive_answer : want);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (outstanding_results.size() == 0) begin
          failures++;
          $error("result with nothing outstanding: status %0d, out_tag %0d", status, out_tag);
        end else begin
          want = outstanding_results.pop_front();
          if (status !== want.status) begin
            failures++;
            $error("status: expected %0d, actual %0d", want.status, status);
          end
          if (out_tag !== want.tag) begin
            failures++;
            $error("out_tag: expected %0d, actual %0d", want.tag, out_tag);
          end
          if (work_pending !== want.work_pending) begin
            failures++;
            $error("work_pending: expected %0d, actual %0d", want.work_pending,
                   work_pending);
          end
          if (occupancy !== want.occupancy) begin
            failures++;
            $error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
          end
        end
      end
      // Watchdog: too long without any transaction on either channel.
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int       target;
    int       phase;
    int       n;
    logic [CFG_DATA_W-1:0] pick;
    rst = 1'b1;
    in_valid = 1'b0;
    op = OP_INSERT;
    tag = '0;
    is_write = 1'b0;
    size_bytes = '0;
    at_head = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_BATCH_COUNT;
    cfg_data = '0;
    drive_fixed = 1'b0;
    drive_answer = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part: reset defaults, field extremes, every operation, zero
    // thresholds and timeout, timer expiry and the ignored register index.
    directed_steps = '{
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_EMPTY, '0, 1'b0, 7'd0),
      checked_row(OP_TICK, '1, 1'b1, SIZE_W'(MAX_REQ_BYTES), 1'b1, ST_ACCEPTED, '0, 1'b0, 7'd0),
      checked_row(OP_MERGE, '0, 1'b0, SIZE_W'(MAX_REQ_BYTES), 1'b0, ST_ACCEPTED, '0, 1'b0, 7'd0),
      checked_row(OP_INSERT, '1, 1'b0, SIZE_W'(MAX_REQ_BYTES), 1'b0, ST_ACCEPTED, '0, 1'b0, 7'd1),
      checked_row(OP_INSERT, '0, 1'b1, '0, 1'b1, ST_ACCEPTED, '0, 1'b0, 7'd2),
      checked_row(OP_MERGE, '0, 1'b1, SIZE_W'(MAX_REQ_BYTES), 1'b0, ST_ACCEPTED, '0, 1'b1, 7'd2),
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_DISPATCHED, '0, 1'b1, 7'd1),
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_DISPATCHED, '1, 1'b1, 7'd0),
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_EMPTY, '0, 1'b0, 7'd0),
      cfg_row(CFG_BATCH_TIMEOUT, 32'd0),
      checked_row(OP_INSERT, 10'h2AA, 1'b1, 21'd1, 1'b0, ST_ACCEPTED, '0, 1'b0, 7'd1),
      checked_row(OP_TICK, '0, 1'b0, '0, 1'b0, ST_ACCEPTED, '0, 1'b1, 7'd1),
      checked_row(OP_TICK, '0, 1'b0, '0, 1'b0, ST_ACCEPTED, '0, 1'b1, 7'd1),
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_DISPATCHED, 10'h2AA, 1'b1, 7'd0),
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_EMPTY, '0, 1'b0, 7'd0),
      cfg_row(CFG_BATCH_COUNT, 32'd0),
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_EMPTY, '0, 1'b1, 7'd0),
      cfg_row(CFG_BATCH_COUNT, 32'(COUNT_MAX)),
      cfg_row(CFG_BATCH_BYTES, '1),
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_EMPTY, '0, 1'b0, 7'd0),
      cfg_row(CFG_BATCH_TIMEOUT, 32'hFFFF),
      checked_row(OP_INSERT, 10'h155, 1'b1, SIZE_W'(MAX_REQ_BYTES), 1'b1, ST_ACCEPTED, '0,
                  1'b0, 7'd1),
      cfg_row(CFG_BATCH_BYTES, 32'd0),
      checked_row(OP_TICK, '0, 1'b0, '0, 1'b0, ST_ACCEPTED, '0, 1'b1, 7'd1),
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_DISPATCHED, 10'h155, 1'b1, 7'd0),
      checked_row(OP_DISPATCH, '0, 1'b0, '0, 1'b0, ST_EMPTY, '0, 1'b1, 7'd0),
      cfg_row(CFG_UNUSED, '1),
      plain_row(OP_INSERT, 10'h0F0, 1'b1, SIZE_W'(MAX_REQ_BYTES), 1'b0),
      plain_row(OP_DISPATCH, 10'h30F, 1'b0, '0, 1'b1)
    };
    foreach (directed_steps[i]) begin
      if (directed_steps[i].is_cfg) begin
        wait_drained();
        write_register(directed_steps[i].idx, directed_steps[i].data);
      end else begin
        send_request(directed_steps[i].rq, directed_steps[i].typed, directed_steps[i].res);
      end
    end

    // Random phases, each starting from an idle block with fresh settings.
    target = requests_sent + RANDOM_ITEMS;
    phase = 0;
    while (requests_sent < target) begin
      wait_drained();
      quiet = (requests_sent + QUIET_ITEMS >= target);
      if (phase == 0 || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 5))
          0:       pick = 32'd0;
          1:       pick = 32'd1;
          2:       pick = 32'(COUNT_MAX);
          3:       pick = $urandom_range(2, 24);
          4:       pick = $urandom_range(0, 65535);
          default: pick = $urandom;  // upper bits are dropped by the block
        endcase
        write_register(CFG_BATCH_COUNT, pick);
        case ($urandom_range(0, 4))
          0:       pick = 32'd0;
          1:       pick = 32'd1;
          2:       pick = '1;
          3:       pick = $urandom_range(1, 200000);
          default: pick = $urandom;
        endcase
        write_register(CFG_BATCH_BYTES, pick);
        case ($urandom_range(0, 4))
          0:       pick = 32'd0;
          1:       pick = 32'd1;
          2:       pick = 32'hFFFF;
          default: pick = $urandom_range(2, 30);
        endcase
        write_register(CFG_BATCH_TIMEOUT, pick);
      end
      case ($urandom_range(0, 2))
        0:       stall_odds = 0;
        1:       stall_odds = 8;
        default: stall_odds = 30;
      endcase
      case ($urandom_range(0, 2))
        0:       gap_odds = 0;
        1:       gap_odds = 8;
        default: gap_odds = 30;
      endcase
      n = $urandom_range(0, 9);
      if (phase == 2) begin
        // The result side holds off while the queue is filled, possibly past full.
        long_hold = 1'b1;
        gap_odds = 0;
        n = 6;
      end
      if (n <= 5) begin
        // A batch: inserts with merges and ticks, then a full drain.
        n = $urandom_range(1, 24);
        for (int k = 0; k < n; k++) begin
          send_request(random_request(OP_INSERT));
          if ($urandom_range(0, 3) == 0) send_request(random_request(OP_MERGE));
          repeat ($urandom_range(0, 2)) send_request(random_request(OP_TICK));
        end
        repeat (n + $urandom_range(1, 3)) send_request(random_request(OP_DISPATCH));
      end else if (n <= 7) begin
        // Send 60 to 72 inserts, which may fill the queue until inserts are refused, then drain it.
        repeat ($urandom_range(60, 72)) send_request(random_request(OP_INSERT));
        repeat (QUEUE_DEPTH + 10) send_request(random_request(OP_DISPATCH));
      end else begin
        repeat ($urandom_range(20, 60)) send_request(random_request(op_t'($urandom_range(0, 3))));
      end
      phase++;
    end

    quiet = 1'b1;
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
